@@ rtl/tei_pkg.sv @@
package tei_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_COUNT_MAX   = 3'd0;
  localparam logic [2:0] REG_START_VALUE = 3'd1;
  localparam logic [2:0] REG_END_VALUE   = 3'd2;
  localparam logic [2:0] REG_DELAY_COUNT = 3'd3;
  localparam logic [2:0] REG_MODE        = 3'd4;

  // Easing codes.
  localparam logic [2:0] EASE_SQUARE = 3'd2;
  localparam logic [2:0] EASE_SQRT   = 3'd4;
  localparam logic [2:0] EASE_COS    = 3'd5;

  // Progress shape codes; the remaining codes are linear.
  localparam logic [3:0] SHAPE_DELAYED   = 4'd1;
  localparam logic [3:0] SHAPE_EARLY     = 4'd2;
  localparam logic [3:0] SHAPE_UP_DOWN   = 4'd3;
  localparam logic [3:0] SHAPE_TRAPEZOID = 4'd4;
  localparam logic [3:0] SHAPE_TRI_UP    = 4'd5;
  localparam logic [3:0] SHAPE_TRI_DOWN  = 4'd6;
  localparam logic [3:0] SHAPE_SAW_UP    = 4'd7;
  localparam logic [3:0] SHAPE_SAW_DOWN  = 4'd8;
  localparam logic [3:0] SHAPE_TRI_TRAIN = 4'd9;
  localparam logic [3:0] SHAPE_SAW_TRAIN = 4'd10;

  // Sine polynomial coefficients in Q2.30.
  localparam logic [31:0] SIN_C1 = 32'd1686629713;
  localparam logic [31:0] SIN_C3 = 32'd693598668;
  localparam logic [31:0] SIN_C5 = 32'd85569306;
  localparam logic [31:0] SIN_C7 = 32'd5026995;
  localparam logic [31:0] SIN_C9 = 32'd172272;

  typedef struct packed {
    logic       rev;
    logic [2:0] ease;
    logic [3:0] shape;
  } mode_dec_t;

  function automatic mode_dec_t decode_mode(input logic [7:0] mode);
    mode_dec_t  dec;
    logic [7:0] m100;
    logic [6:0] base;
    dec.rev = (mode >= 8'd100) && (mode < 8'd200);
    if (mode >= 8'd200) begin
      m100 = mode - 8'd200;
    end else if (mode >= 8'd100) begin
      m100 = mode - 8'd100;
    end else begin
      m100 = mode;
    end
    if (m100 >= 8'd90) begin
      dec.ease = 3'd6;
    end else if (m100 >= 8'd75) begin
      dec.ease = 3'd5;
    end else if (m100 >= 8'd60) begin
      dec.ease = 3'd4;
    end else if (m100 >= 8'd45) begin
      dec.ease = 3'd3;
    end else if (m100 >= 8'd30) begin
      dec.ease = 3'd2;
    end else if (m100 >= 8'd15) begin
      dec.ease = 3'd1;
    end else begin
      dec.ease = 3'd0;
    end
    base = 7'(dec.ease) * 7'd15;
    dec.shape = 4'(m100[6:0] - base);
    return dec;
  endfunction

endpackage

@@ rtl/tei_div.sv @@
module tei_div #(
  parameter int DW  = 16,
  parameter int DVW = 16,
  parameter int QW  = 16,
  parameter int SW  = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [DW-1:0]  dividend_i,
  input  logic [DVW-1:0] divisor_i,
  input  logic [SW-1:0]  side_i,
  output logic           valid_o,
  output logic [QW-1:0]  quot_o,
  output logic [DVW-1:0] rem_o,
  output logic [SW-1:0]  side_o
);

  // One quotient bit per stage; the dividend's top bits must lie below the divisor.
  logic [QW-1:0]  valid_q;
  logic [DVW-1:0] rem_q  [QW];
  logic [DVW-1:0] dsr_q  [QW];
  logic [QW-1:0]  low_q  [QW];
  logic [QW-1:0]  quot_q [QW];
  logic [SW-1:0]  side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           v_in;
    logic [DVW-1:0] rem_in;
    logic [DVW-1:0] dsr_in;
    logic [QW-1:0]  low_in;
    logic [QW-1:0]  quot_in;
    logic [SW-1:0]  side_in;
    logic [DVW:0]   trial;
    logic           ge;
    logic [DVW-1:0] rem_d;
    logic [QW-1:0]  quot_d;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = DVW'(dividend_i >> QW);
      assign dsr_in  = divisor_i;
      assign low_in  = dividend_i[QW-1:0];
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign dsr_in  = dsr_q[k-1];
      assign low_in  = low_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      trial  = {rem_in, low_in[QW-1-k]};
      ge     = trial >= {1'b0, dsr_in};
      rem_d  = ge ? DVW'(trial - {1'b0, dsr_in}) : DVW'(trial);
      quot_d = quot_in;
      quot_d[QW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        dsr_q[k]  <= dsr_in;
        low_q[k]  <= low_in;
        quot_q[k] <= quot_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign rem_o   = rem_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

@@ rtl/tei_ease.sv @@
module tei_ease #(
  parameter int F = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  logic [F:0] p_i,
  input  logic [2:0] ease_i,
  output logic       valid_o,
  output logic [F:0] p_o
);

  // Square root takes one result bit per stage; the sine runs alongside it.
  localparam int NE = F + 1;
  localparam int XW = 2 * F + 2;
  localparam logic [31:0] ONE32 = 32'(1) << F;

  logic [NE-1:0] valid_q;
  logic [F:0]    p_q  [NE];
  logic [XW-1:0] x_q  [NE];
  logic [XW-1:0] r_q  [NE];
  logic [30:0]   t_q  [NE];
  logic [30:0]   t2_q [NE];
  logic [31:0]   c_q  [NE];
  logic [F:0]    sq_q [NE];

  for (genvar k = 0; k < NE; k++) begin : g_stage
    localparam logic [XW-1:0] BIT = XW'(1) << (2 * F - 2 * k);
    logic          v_in;
    logic [F:0]    p_in;
    logic [XW-1:0] x_in;
    logic [XW-1:0] r_in;
    logic [30:0]   t_in;
    logic [30:0]   t2_in;
    logic [31:0]   c_in;
    logic [F:0]    sq_in;
    logic [XW-1:0] x_d;
    logic [XW-1:0] r_d;
    logic [30:0]   t_d;
    logic [30:0]   t2_d;
    logic [31:0]   c_d;
    logic [F:0]    sq_d;
    logic [XW-1:0] rb;
    logic [63:0]   mul;
    logic [61:0]   tt;
    logic [XW-1:0] pp;
    logic [31:0]   rnd;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign p_in  = p_i;
      assign x_in  = XW'(p_i) << F;
      assign r_in  = '0;
      assign t_in  = '0;
      assign t2_in = '0;
      assign c_in  = '0;
      assign sq_in = '0;
    end else begin : g_next
      assign v_in  = valid_q[k-1];
      assign p_in  = p_q[k-1];
      assign x_in  = x_q[k-1];
      assign r_in  = r_q[k-1];
      assign t_in  = t_q[k-1];
      assign t2_in = t2_q[k-1];
      assign c_in  = c_q[k-1];
      assign sq_in = sq_q[k-1];
    end

    always_comb begin
      // Square root, one digit a stage.
      rb = r_in + BIT;
      if (x_in >= rb) begin
        x_d = x_in - rb;
        r_d = (r_in >> 1) + BIT;
      end else begin
        x_d = x_in;
        r_d = r_in >> 1;
      end

      t_d  = t_in;
      t2_d = t2_in;
      c_d  = c_in;
      sq_d = sq_in;
      mul  = '0;
      tt   = '0;
      pp   = '0;
      rnd  = '0;
      case (k)
        0: begin
          t_d  = 31'(p_in) << (30 - F);
          tt   = 62'(t_d) * 62'(t_d);
          t2_d = 31'(tt >> 30);
          pp   = XW'(p_in) * XW'(p_in) + (XW'(1) << (F - 1));
          sq_d = (F + 1)'(pp >> F);
        end
        1: begin
          mul = 64'(tei_pkg::SIN_C9) * 64'(t2_in);
          c_d = tei_pkg::SIN_C7 - 32'(mul >> 30);
        end
        2: begin
          mul = 64'(c_in) * 64'(t2_in);
          c_d = tei_pkg::SIN_C5 - 32'(mul >> 30);
        end
        3: begin
          mul = 64'(c_in) * 64'(t2_in);
          c_d = tei_pkg::SIN_C3 - 32'(mul >> 30);
        end
        4: begin
          mul = 64'(c_in) * 64'(t2_in);
          c_d = tei_pkg::SIN_C1 - 32'(mul >> 30);
        end
        5: begin
          mul = 64'(c_in) * 64'(t_in);
          c_d = 32'(mul >> 30);
        end
        6: begin
          mul = 64'(c_in) * 64'(c_in);
          c_d = 32'(mul >> 30);
        end
        7: begin
          rnd = (c_in + (32'(1) << (29 - F))) >> (30 - F);
          c_d = (rnd > ONE32) ? ONE32 : rnd;
        end
        default: begin
          c_d = c_in;
        end
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[k]  <= p_in;
        x_q[k]  <= x_d;
        r_q[k]  <= r_d;
        t_q[k]  <= t_d;
        t2_q[k] <= t2_d;
        c_q[k]  <= c_d;
        sq_q[k] <= sq_d;
      end
    end
  end

  assign valid_o = valid_q[NE-1];

  always_comb begin
    case (ease_i)
      tei_pkg::EASE_SQUARE: p_o = sq_q[NE-1];
      tei_pkg::EASE_SQRT:   p_o = r_q[NE-1][F:0];
      tei_pkg::EASE_COS:    p_o = c_q[NE-1][F:0];
      default:              p_o = p_q[NE-1];
    endcase
  end

endmodule

@@ rtl/tween_easing_interpolator_unit.sv @@
// Items pass stage A, the period divider, stage B, the fraction divider, easing, M and output.
// Throughput: one count per cycle unless a stall holds the pipeline; the two bit-per-stage
// dividers and the square root pipeline set the depth, not the rate.
// Reset clears all valid bits, sets count_max to one and the other config registers to zero.
// The whole pipeline holds while a finished value waits and value_ready_i is low.
module tween_easing_interpolator_unit #(
  parameter int COUNT_WIDTH = 16,
  parameter int VALUE_WIDTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [4:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   count_valid_i,
  output logic                   count_ready_o,
  input  logic [COUNT_WIDTH-1:0] count_i,
  output logic                   value_valid_o,
  input  logic                   value_ready_i,
  output logic [VALUE_WIDTH-1:0] value_o
);

  localparam int CW = COUNT_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = CW + 3;
  localparam int PW = VW + F + 3;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  // Configuration registers.
  logic [CW-1:0] count_max_q;
  logic [VW-1:0] start_value_q;
  logic [VW-1:0] end_value_q;
  logic [CW-1:0] delay_count_q;
  logic [7:0]    mode_q;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_max_q   <= CW'(1);
      start_value_q <= '0;
      end_value_q   <= '0;
      delay_count_q <= '0;
      mode_q        <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        tei_pkg::REG_COUNT_MAX:   count_max_q   <= pwdata[CW-1:0];
        tei_pkg::REG_START_VALUE: start_value_q <= pwdata[VW-1:0];
        tei_pkg::REG_END_VALUE:   end_value_q   <= pwdata[VW-1:0];
        tei_pkg::REG_DELAY_COUNT: delay_count_q <= pwdata[CW-1:0];
        tei_pkg::REG_MODE:        mode_q        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tei_pkg::REG_COUNT_MAX:   prdata = 32'(count_max_q);
      tei_pkg::REG_START_VALUE: prdata = 32'(start_value_q);
      tei_pkg::REG_END_VALUE:   prdata = 32'(end_value_q);
      tei_pkg::REG_DELAY_COUNT: prdata = 32'(delay_count_q);
      tei_pkg::REG_MODE:        prdata = 32'(mode_q);
      default:                  prdata = '0;
    endcase
  end

  tei_pkg::mode_dec_t dec;
  logic [CW-1:0]      m_eff;
  logic [CW-1:0]      w_eff;

  assign dec   = tei_pkg::decode_mode(mode_q);
  assign m_eff = (count_max_q == '0) ? CW'(1) : count_max_q;
  assign w_eff = (delay_count_q == '0) ? CW'(1) : delay_count_q;

  // Every stage moves together; a stall holds them all.
  logic en;
  assign en            = !value_valid_o || value_ready_i;
  assign count_ready_o = en;

  // Stage A: clamp the frame number.
  logic          a_valid_q;
  logic [CW-1:0] a_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= count_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_c_q <= (count_i > m_eff) ? m_eff : count_i;
    end
  end

  // Position inside the wave period.
  logic          d1_valid;
  logic [CW-1:0] d1_quot;
  logic [CW-1:0] d1_rem;
  logic [CW-1:0] d1_c;

  tei_div #(
    .DW (CW),
    .DVW(CW),
    .QW (CW),
    .SW (CW)
  ) u_period_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (a_valid_q),
    .dividend_i(a_c_q),
    .divisor_i (w_eff),
    .side_i    (a_c_q),
    .valid_o   (d1_valid),
    .quot_o    (d1_quot),
    .rem_o     (d1_rem),
    .side_o    (d1_c)
  );

  // Stage B: pick numerator and denominator of the progress fraction.
  logic signed [NW-1:0] sc, sm, sdc, sw, sw2, sw4, swc, swc2;
  logic signed [NW-1:0] tri_num, slast, shalf, sla, snum, sden, den_c;
  logic                 b_zero_d, b_one_d;
  logic                 b_valid_q, b_zero_q, b_one_q;
  logic [CW-1:0]        b_num_q, b_den_q;

  always_comb begin
    sc   = $signed(NW'(d1_c));
    sm   = $signed(NW'(m_eff));
    sdc  = $signed(NW'(delay_count_q));
    sw   = $signed(NW'(w_eff));
    sw2  = sw <<< 1;
    sw4  = sw <<< 2;
    swc  = $signed(NW'(d1_rem));
    swc2 = d1_quot[0] ? swc + sw : swc;
    tri_num = (swc2 < sw) ? swc2 : sw2 - swc2;
    slast = sm - sw4;
    shalf = slast >>> 1;
    if (shalf < NW'(1)) begin
      shalf = NW'(1);
    end
    sla  = sc - sw4;
    snum = sc;
    sden = sm;
    case (dec.shape)
      tei_pkg::SHAPE_DELAYED: begin
        if (sc < sdc) begin
          snum = '0;
          sden = NW'(1);
        end else begin
          snum = sc - sdc;
          sden = sm - sdc;
        end
      end
      tei_pkg::SHAPE_EARLY: begin
        if (sc < sdc) begin
          snum = sc;
          sden = sw;
        end else begin
          snum = NW'(1);
          sden = NW'(1);
        end
      end
      tei_pkg::SHAPE_UP_DOWN: begin
        if (sc < sdc) begin
          snum = sc;
          sden = sw;
        end else begin
          snum = sm - sc;
          sden = sm - sdc;
        end
      end
      tei_pkg::SHAPE_TRAPEZOID: begin
        if (sc < sdc) begin
          snum = sc;
          sden = sw;
        end else if (sc >= sm - sdc) begin
          snum = sm - sc;
          sden = sw;
        end else begin
          snum = NW'(1);
          sden = NW'(1);
        end
      end
      tei_pkg::SHAPE_TRI_UP: begin
        snum = tri_num;
        sden = sw;
      end
      tei_pkg::SHAPE_TRI_DOWN: begin
        snum = (swc2 < sw) ? sw - swc2 : swc2 - sw;
        sden = sw;
      end
      tei_pkg::SHAPE_SAW_UP: begin
        snum = swc;
        sden = sw;
      end
      tei_pkg::SHAPE_SAW_DOWN: begin
        snum = sw - swc;
        sden = sw;
      end
      tei_pkg::SHAPE_TRI_TRAIN: begin
        if (sc <= sw4) begin
          snum = tri_num;
          sden = sw;
        end else begin
          snum = (sla <= shalf) ? sla : slast - sla;
          sden = shalf;
        end
      end
      tei_pkg::SHAPE_SAW_TRAIN: begin
        if (sc <= sw2) begin
          snum = swc;
          sden = sw;
        end else begin
          snum = sc - sw2;
          sden = sm - sw2;
        end
      end
      default: begin
        snum = sc;
        sden = sm;
      end
    endcase
    den_c    = (sden < NW'(1)) ? NW'(1) : sden;
    b_zero_d = snum <= NW'(0);
    b_one_d  = snum >= den_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_zero_q <= b_zero_d;
      b_one_q  <= b_one_d;
      b_num_q  <= snum[CW-1:0];
      b_den_q  <= den_c[CW-1:0];
    end
  end

  // Progress fraction, rounded to nearest.
  logic [CW+F:0] fr_dividend;
  logic          d2_valid;
  logic [F:0]    d2_quot;
  logic [CW-1:0] d2_rem;
  logic [1:0]    d2_flags;
  logic [F:0]    prog;

  assign fr_dividend = (CW + F + 1)'({b_num_q, {F{1'b0}}}) + (CW + F + 1)'(b_den_q >> 1);

  tei_div #(
    .DW (CW + F + 1),
    .DVW(CW),
    .QW (F + 1),
    .SW (2)
  ) u_frac_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (b_valid_q),
    .dividend_i(fr_dividend),
    .divisor_i (b_den_q),
    .side_i    ({b_zero_q, b_one_q}),
    .valid_o   (d2_valid),
    .quot_o    (d2_quot),
    .rem_o     (d2_rem),
    .side_o    (d2_flags)
  );

  assign prog = d2_flags[1] ? '0 : (d2_flags[0] ? ONE : d2_quot);

  logic       e_valid;
  logic [F:0] e_p;

  tei_ease #(
    .F(F)
  ) u_ease (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(d2_valid),
    .p_i    (prog),
    .ease_i (dec.ease),
    .valid_o(e_valid),
    .p_o    (e_p)
  );

  // Stage M: scale the span by the progress.
  logic signed [VW-1:0] s_val, e_val;
  logic signed [PW-1:0] diff;
  logic                 m_valid_q;
  logic signed [PW-1:0] m_prod_q;

  assign s_val = dec.rev ? $signed(end_value_q) : $signed(start_value_q);
  assign e_val = dec.rev ? $signed(start_value_q) : $signed(end_value_q);
  assign diff  = PW'(e_val) - PW'(s_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= e_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_prod_q <= diff * $signed(PW'(e_p));
    end
  end

  // Output stage: add the start, add one half and truncate toward zero.
  logic signed [PW-1:0] total;
  logic        [PW-1:0] mag;
  logic        [PW-1:0] res;
  logic                 value_valid_q;
  logic [VW-1:0]        value_q;

  always_comb begin
    total = m_prod_q + (PW'(s_val) <<< F) + $signed(PW'(1) << (F - 1));
    if (total[PW-1]) begin
      mag = (PW'(0) - PW'(total)) >> F;
      res = PW'(0) - mag;
    end else begin
      mag = PW'(total) >> F;
      res = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_valid_q <= 1'b0;
    end else if (en) begin
      value_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= res[VW-1:0];
    end
  end

  assign value_valid_o = value_valid_q;
  assign value_o       = value_q;

  // The fraction divider must never see a zero divisor.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> b_den_q != '0)
    else $error("progress denominator is zero");

  // A proper fraction never rounds above one; flagged items bypass the quotient.
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_valid && (d2_flags == 2'b00) |-> d2_quot <= ONE)
    else $error("progress fraction above one");

  // Every easing curve keeps progress within one.
  a_ease_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_valid |-> e_p <= ONE)
    else $error("eased progress above one");

  // A stalled pipeline keeps the item in stage M.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && !en |=> m_valid_q && $stable(m_prod_q))
    else $error("item lost during a stall");

endmodule
